// ===== design/tar_stream_deframer_unit_assert.svh =====
// assertion macros for the tar stream deframer
// used by tar_stream_deframer_unit, no other dependencies
`ifndef TAR_STREAM_DEFRAMER_UNIT_ASSERT_SVH
`define TAR_STREAM_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define TSD_ASSERT_IMPL(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsd same-cycle check failed");

// next-cycle implication
`define TSD_ASSERT_NEXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsd next-cycle check failed");

`endif

// ===== design/tsd_pkg.sv =====
// shared types and constants for the tar stream deframer
// no dependencies
`timescale 1ns / 1ps
package tsd_pkg;

	localparam int ENTRY_SIZE_W = 36;
	localparam int SUM_W        = 17;
	localparam int SUM_FIELD_W  = 24;
	localparam int OFS_W        = 9;

	localparam logic [OFS_W-1:0] OFS_SIZE_FIRST = 9'd124;
	localparam logic [OFS_W-1:0] OFS_SIZE_LAST  = 9'd135;
	localparam logic [OFS_W-1:0] OFS_CKS_FIRST  = 9'd148;
	localparam logic [OFS_W-1:0] OFS_CKS_LAST   = 9'd155;
	localparam logic [OFS_W-1:0] OFS_TYPE       = 9'd156;
	localparam logic [OFS_W-1:0] OFS_BLOCK_LAST = 9'd511;

	localparam logic [7:0] CKS_BLANK = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_HLINK  = 8'h31;
	localparam logic [7:0] CH_SLINK  = 8'h32;
	localparam logic [7:0] CH_CHR    = 8'h33;
	localparam logic [7:0] CH_BLK    = 8'h34;
	localparam logic [7:0] CH_DIR    = 8'h35;
	localparam logic [7:0] CH_FIFO   = 8'h36;

	localparam logic [1:0] EV_HEADER  = 2'd0;
	localparam logic [1:0] EV_PAYLOAD = 2'd1;
	localparam logic [1:0] EV_END     = 2'd2;
	localparam logic [1:0] EV_ERROR   = 2'd3;

	localparam logic [2:0] ERR_SHORT    = 3'd0;
	localparam logic [2:0] ERR_CHECKSUM = 3'd1;
	localparam logic [2:0] ERR_LINK     = 3'd2;
	localparam logic [2:0] ERR_OVERRUN  = 3'd3;
	localparam logic [2:0] ERR_NO_END   = 3'd4;

	localparam logic [1:0] KIND_REG  = 2'd0;
	localparam logic [1:0] KIND_DIR  = 2'd1;
	localparam logic [1:0] KIND_LINK = 2'd2;

	localparam int RES_Q_DEPTH = 4;
	localparam int RES_Q_AW    = $clog2(RES_Q_DEPTH);
	localparam int RES_Q_LW    = RES_Q_AW + 1;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_PADDING = 4'b0100,
		PH_STOPPED = 4'b1000
	} phase_t;

	typedef struct packed {
		logic                    all_zero;
		logic                    sum_ok;
		logic [1:0]              kind;
		logic [ENTRY_SIZE_W-1:0] size;
	} hdr_info_t;

	typedef struct packed {
		logic [1:0]              ev;
		logic [2:0]              err;
		logic [1:0]              kind;
		logic [ENTRY_SIZE_W-1:0] size;
		logic [7:0]              pbyte;
		logic                    done;
		logic                    last_res;
	} res_t;

endpackage

// ===== design/tsd_hdr_parse.sv =====
// header block accumulators: checksum sum, octal size and checksum fields, type byte
// depends on tsd_pkg
`timescale 1ns / 1ps
module tsd_hdr_parse #(
	parameter int SIZE_BITS = 36
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               clear,
	input  logic [tsd_pkg::OFS_W-1:0] offset,
	input  logic [7:0]         data,
	output tsd_pkg::hdr_info_t info
);
	import tsd_pkg::*;

	typedef enum logic [2:0] {
		OCT_SKIP   = 3'b001,
		OCT_DIGITS = 3'b010,
		OCT_DONE   = 3'b100
	} oct_t;

	typedef struct packed {
		oct_t                    ph;
		logic [ENTRY_SIZE_W-1:0] acc;
	} oct_res_t;

	function automatic oct_res_t oct_step(oct_t ph, logic [ENTRY_SIZE_W-1:0] acc,
			logic [7:0] b);
		oct_res_t r;
		logic     dig;
		r.ph  = ph;
		r.acc = acc;
		dig   = (b >= CH_ZERO) && (b <= CH_SEVEN);
		unique case (ph)
			OCT_SKIP: begin
				if (dig) begin
					r.acc = ENTRY_SIZE_W'(b[2:0]);
					r.ph  = OCT_DIGITS;
				end
			end
			OCT_DIGITS: begin
				if (dig) begin
					r.acc = {acc[ENTRY_SIZE_W-4:0], b[2:0]};
				end else begin
					r.ph = OCT_DONE;
				end
			end
			OCT_DONE: begin
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	logic [SUM_W-1:0]       sum_q, sum_d;
	logic                   zero_q, zero_d;
	logic [SIZE_BITS-1:0]   size_q;
	oct_t                   size_ph_q;
	logic [SUM_FIELD_W-1:0] cks_q;
	oct_t                   cks_ph_q;
	logic [7:0]             type_q;
	logic                   in_cks, in_size;
	oct_res_t               size_nx, cks_nx;
	logic [1:0]             kind;

	assign in_cks  = (offset >= OFS_CKS_FIRST) && (offset <= OFS_CKS_LAST);
	assign in_size = (offset >= OFS_SIZE_FIRST) && (offset <= OFS_SIZE_LAST);

	always_comb begin
		sum_d   = sum_q + SUM_W'(in_cks ? CKS_BLANK : data);
		zero_d  = zero_q && (data == 8'd0);
		size_nx = oct_step(size_ph_q, ENTRY_SIZE_W'(size_q), data);
		cks_nx  = oct_step(cks_ph_q, ENTRY_SIZE_W'(cks_q), data);
	end

	always_comb begin
		priority if (type_q == CH_HLINK || type_q == CH_SLINK || type_q == CH_CHR ||
				type_q == CH_BLK || type_q == CH_FIFO) begin
			kind = KIND_LINK;
		end else if (type_q == CH_DIR) begin
			kind = KIND_DIR;
		end else begin
			kind = KIND_REG;
		end
	end

	assign info.all_zero = zero_d;
	assign info.sum_ok   = (SUM_FIELD_W'(sum_d) == cks_q);
	assign info.kind     = kind;
	assign info.size     = (kind == KIND_DIR) ? '0 : ENTRY_SIZE_W'(size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			zero_q    <= 1'b1;
			size_q    <= '0;
			size_ph_q <= OCT_SKIP;
			cks_q     <= '0;
			cks_ph_q  <= OCT_SKIP;
			type_q    <= '0;
		end else if (clear) begin
			sum_q     <= '0;
			zero_q    <= 1'b1;
			size_q    <= '0;
			size_ph_q <= OCT_SKIP;
			cks_q     <= '0;
			cks_ph_q  <= OCT_SKIP;
			type_q    <= '0;
		end else if (step) begin
			sum_q  <= sum_d;
			zero_q <= zero_d;
			if (in_cks) begin
				cks_q    <= cks_nx.acc[SUM_FIELD_W-1:0];
				cks_ph_q <= cks_nx.ph;
			end
			if (in_size) begin
				size_q    <= size_nx.acc[SIZE_BITS-1:0];
				size_ph_q <= size_nx.ph;
			end
			if (offset == OFS_TYPE) begin
				type_q <= data;
			end
		end
	end

endmodule

// ===== design/tsd_res_fifo.sv =====
// small result queue, takes up to two results per cycle, gives one
// depends on tsd_pkg
`timescale 1ns / 1ps
module tsd_res_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push0,
	input  logic                         push1,
	input  tsd_pkg::res_t                res0,
	input  tsd_pkg::res_t                res1,
	input  logic                         pop,
	output tsd_pkg::res_t                head,
	output logic [tsd_pkg::RES_Q_LW-1:0] level
);
	import tsd_pkg::*;

	res_t                mem_q [RES_Q_DEPTH];
	logic [RES_Q_AW-1:0] wr_q, rd_q;
	logic [RES_Q_LW-1:0] level_q;

	assign head  = mem_q[rd_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= res0;
		end
		if (push1) begin
			mem_q[wr_q + RES_Q_AW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_Q_AW'(push0) + RES_Q_AW'(push1);
			rd_q    <= rd_q + RES_Q_AW'(pop);
			level_q <= level_q + RES_Q_LW'(push0) + RES_Q_LW'(push1) - RES_Q_LW'(pop);
		end
	end

endmodule

// ===== design/tar_stream_deframer_unit.sv =====
// top level of the tar stream deframer: input register, block phase control
// depends on tsd_pkg, tsd_hdr_parse, tsd_res_fifo, tar_stream_deframer_unit_assert.svh
//
// channel  handshake            beat contents
// in       in_valid / in_ready  data_byte, stream_last
// out      out_valid/ out_ready event_res, error_code, entry_kind, entry_size,
//                               payload_byte, entry_done, step_final
//
// one byte per cycle while the queue has room; a byte is held in the input register, then its
// zero, one or two results enter a four-entry result queue
// the input register moves on only while the queue has room for two results
// reset clears phase, offset, accumulators and queue at once, no sweep
`timescale 1ns / 1ps
module tar_stream_deframer_unit #(
	parameter int SIZE_BITS = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic [2:0]  error_code,
	output logic [1:0]  entry_kind,
	output logic [35:0] entry_size,
	output logic [7:0]  payload_byte,
	output logic        entry_done,
	output logic        step_final
);
	import tsd_pkg::*;

	logic                 valid_s1, last_s1;
	logic [7:0]           byte_s1;
	logic                 fire;
	phase_t               phase_q, phase_d;
	logic [OFS_W-1:0]     offset_q, offset_d;
	logic [SIZE_BITS-1:0] left_q, left_d, left_dec;
	hdr_info_t            hdr;
	logic                 size_nz;
	logic                 push0, push1;
	res_t                 res0, res1, head;
	logic [RES_Q_LW-1:0]  level;
	logic                 hdr_step, hdr_clear;

	assign fire     = valid_s1 && (level <= RES_Q_LW'(RES_Q_DEPTH - 2));
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= stream_last;
		end
	end

	assign hdr_step  = fire && (phase_q == PH_HEADER);
	assign hdr_clear = fire && (last_s1 || (phase_q == PH_HEADER &&
		offset_q == OFS_BLOCK_LAST));

	tsd_hdr_parse #(
		.SIZE_BITS(SIZE_BITS)
	) u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (hdr_step),
		.clear  (hdr_clear),
		.offset (offset_q),
		.data   (byte_s1),
		.info   (hdr)
	);

	assign size_nz  = |hdr.size;
	assign left_dec = left_q - SIZE_BITS'(1);

	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		left_d   = left_q;
		push0    = 1'b0;
		push1    = 1'b0;
		res0     = '0;
		res1     = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (offset_q == OFS_BLOCK_LAST) begin
					offset_d = '0;
					push0    = 1'b1;
					phase_d  = PH_STOPPED;
					priority if (hdr.all_zero) begin
						res0.ev = EV_END;
					end else if (!hdr.sum_ok) begin
						res0.ev  = EV_ERROR;
						res0.err = ERR_CHECKSUM;
					end else if (hdr.kind == KIND_LINK && size_nz) begin
						res0.ev   = EV_ERROR;
						res0.err  = ERR_LINK;
						res0.kind = hdr.kind;
						res0.size = hdr.size;
					end else if (last_s1 && size_nz) begin
						res0.ev  = EV_ERROR;
						res0.err = ERR_OVERRUN;
					end else begin
						res0.ev   = EV_HEADER;
						res0.kind = hdr.kind;
						res0.size = hdr.size;
						res0.done = !size_nz;
						phase_d   = size_nz ? PH_PAYLOAD : PH_HEADER;
						left_d    = hdr.size[SIZE_BITS-1:0];
						if (last_s1) begin
							push1    = 1'b1;
							res1.ev  = EV_ERROR;
							res1.err = ERR_NO_END;
						end
					end
				end else begin
					offset_d = offset_q + OFS_W'(1);
					if (last_s1) begin
						push0    = 1'b1;
						res0.ev  = EV_ERROR;
						res0.err = ERR_SHORT;
					end
				end
			end
			PH_PAYLOAD: begin
				push0 = 1'b1;
				if (last_s1) begin
					res0.ev  = EV_ERROR;
					res0.err = ERR_OVERRUN;
				end else begin
					offset_d   = offset_q + OFS_W'(1);
					left_d     = left_dec;
					res0.ev    = EV_PAYLOAD;
					res0.pbyte = byte_s1;
					res0.done  = (left_dec == '0);
					if (left_dec == '0) begin
						phase_d = (offset_d == '0) ? PH_HEADER : PH_PADDING;
					end
				end
			end
			PH_PADDING: begin
				offset_d = offset_q + OFS_W'(1);
				if (last_s1) begin
					push0    = 1'b1;
					res0.ev  = EV_ERROR;
					res0.err = ERR_NO_END;
				end else if (offset_d == '0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_STOPPED: begin
			end
			default: begin
			end
		endcase
		res0.last_res = !push1;
		res1.last_res = 1'b1;
		if (last_s1) begin
			phase_d  = PH_HEADER;
			offset_d = '0;
			left_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			offset_q <= '0;
			left_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			left_q   <= left_d;
		end
	end

	tsd_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (fire && push0),
		.push1  (fire && push1),
		.res0   (res0),
		.res1   (res1),
		.pop    (out_valid && out_ready),
		.head   (head),
		.level  (level)
	);

	assign out_valid    = (level != '0);
	assign event_res    = head.ev;
	assign error_code   = head.err;
	assign entry_kind   = head.kind;
	assign entry_size   = head.size;
	assign payload_byte = head.pbyte;
	assign entry_done   = head.done;
	assign step_final   = head.last_res;

	`include "tar_stream_deframer_unit_assert.svh"

	`TSD_ASSERT_IMPL(a_level_bound, clk, arst_n, 1'b1, level <= RES_Q_LW'(RES_Q_DEPTH))
	`TSD_ASSERT_IMPL(a_two_only_hdr, clk, arst_n, fire && push1, res0.ev == EV_HEADER && last_s1)
	`TSD_ASSERT_IMPL(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, left_q != '0)
	`TSD_ASSERT_NEXT(a_last_resets, clk, arst_n, fire && last_s1, phase_q == PH_HEADER && offset_q == '0)

endmodule

// ===== dv/tar_stream_deframer_unit_test.sv =====
// testbench for tar_stream_deframer_unit: directed archives, then random ones,
// every output beat checked against a byte-level parser model kept in this file
// depends on tsd_pkg and the tar_stream_deframer_unit rtl
`timescale 1ns / 1ps
module tar_stream_deframer_unit_test;
	import tsd_pkg::*;

	localparam int SZ_W = ENTRY_SIZE_W;
	localparam logic [SZ_W-1:0] SZ_MAX = '1;
	localparam logic [SZ_W-1:0] CKS_MASK = SZ_W'({SUM_FIELD_W{1'b1}});
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_JUNK = 8'h78;
	localparam int RANDOM_BYTES = 1700;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {FLD_SKIP, FLD_DIGITS, FLD_DONE} fld_phase_t;
	typedef enum {OP_BYTE, OP_HDR, OP_ZERO, OP_DATA} row_op_t;

	typedef struct {
		row_op_t         op;
		logic [7:0]      val;
		logic [7:0]      typ;
		logic [SZ_W-1:0] size;
		int              cnt;
		int              cut;
		bit              cks_bad;
		bit              last;
		bit              typed;
		logic [1:0]      t_ev;
		logic [2:0]      t_err;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        stream_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  event_res;
	logic [2:0]  error_code;
	logic [1:0]  entry_kind;
	logic [35:0] entry_size;
	logic [7:0]  payload_byte;
	logic        entry_done;
	logic        step_final;

	tar_stream_deframer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.stream_last(stream_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.error_code(error_code),
		.entry_kind(entry_kind),
		.entry_size(entry_size),
		.payload_byte(payload_byte),
		.entry_done(entry_done),
		.step_final(step_final)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// parser model state
	logic [OFS_W-1:0]       blk_ofs;
	phase_t                 blk_phase;
	logic [SUM_W-1:0]       hdr_sum;
	logic                   hdr_zero;
	logic [SZ_W-1:0]        size_acc;
	fld_phase_t             size_ph;
	logic [SUM_FIELD_W-1:0] cks_acc;
	fld_phase_t             cks_ph;
	logic [7:0]             type_char;
	logic [SZ_W-1:0]        bytes_left;

	res_t step_res[$];
	res_t pending_res[$];
	logic [7:0] hdr_img [512];

	int bytes_sent = 0;
	int buffers = 0;
	int res_seen = 0;
	int mismatches = 0;
	int ev_tally [4] = '{0, 0, 0, 0};
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_stall = 0;
	int rx_cyc = 0;
	int rx_pick;

	function automatic res_t mk_res(logic [1:0] ev, logic [2:0] err, logic [1:0] kind,
			logic [SZ_W-1:0] size, logic [7:0] pb, logic done);
		res_t r;
		r.ev = ev;
		r.err = err;
		r.kind = kind;
		r.size = size;
		r.pbyte = pb;
		r.done = done;
		r.last_res = 1'b0;
		return r;
	endfunction

	function automatic void clear_hdr();
		hdr_sum = '0;
		hdr_zero = 1'b1;
		size_acc = '0;
		size_ph = FLD_SKIP;
		cks_acc = '0;
		cks_ph = FLD_SKIP;
		type_char = 8'h00;
	endfunction

	function automatic void restart_parse();
		blk_ofs = '0;
		blk_phase = PH_HEADER;
		bytes_left = '0;
		clear_hdr();
	endfunction

	function automatic void octal_feed(inout fld_phase_t ph, inout logic [SZ_W-1:0] acc,
			input logic [7:0] b, input logic [SZ_W-1:0] mask);
		logic is_dig;
		logic [SZ_W-1:0] d;
		is_dig = (b >= CH_ZERO) && (b <= CH_SEVEN);
		d = SZ_W'(b[2:0]);
		case (ph)
			FLD_SKIP: if (is_dig) begin
				acc = d & mask;
				ph = FLD_DIGITS;
			end
			FLD_DIGITS: if (is_dig) acc = ((acc << 3) | d) & mask;
				else ph = FLD_DONE;
			default: ;
		endcase
	endfunction

	task automatic finish_hdr(input bit last);
		logic [1:0] kind;
		logic [SZ_W-1:0] size;
		size = size_acc;
		if (hdr_zero) begin
			step_res.push_back(mk_res(EV_END, ERR_NONE, KIND_REG, '0, 8'h00, 1'b0));
			blk_phase = PH_STOPPED;
		end else if (SUM_FIELD_W'(hdr_sum) != cks_acc) begin
			step_res.push_back(mk_res(EV_ERROR, ERR_CHECKSUM, KIND_REG, '0, 8'h00, 1'b0));
			blk_phase = PH_STOPPED;
		end else begin
			case (type_char)
				CH_HLINK, CH_SLINK, CH_CHR, CH_BLK, CH_FIFO: kind = KIND_LINK;
				CH_DIR: kind = KIND_DIR;
				default: kind = KIND_REG;
			endcase
			if (kind == KIND_DIR)
				size = '0;
			if (kind == KIND_LINK && size != 0) begin
				step_res.push_back(mk_res(EV_ERROR, ERR_LINK, kind, size, 8'h00, 1'b0));
				blk_phase = PH_STOPPED;
			end else if (last && size != 0) begin
				step_res.push_back(mk_res(EV_ERROR, ERR_OVERRUN, KIND_REG, '0, 8'h00, 1'b0));
				blk_phase = PH_STOPPED;
			end else begin
				step_res.push_back(mk_res(EV_HEADER, ERR_NONE, kind, size, 8'h00, size == 0));
				if (size != 0) begin
					blk_phase = PH_PAYLOAD;
					bytes_left = size;
				end else begin
					blk_phase = PH_HEADER;
				end
				if (last)
					step_res.push_back(mk_res(EV_ERROR, ERR_NO_END, KIND_REG, '0, 8'h00, 1'b0));
			end
		end
		blk_ofs = '0;
		clear_hdr();
	endtask

	task automatic deframe_step(input logic [7:0] b, input bit last);
		logic [OFS_W-1:0] o;
		logic [SZ_W-1:0] tmp;
		res_t r;
		step_res.delete();
		o = blk_ofs;
		case (blk_phase)
			PH_HEADER: begin
				if (o >= OFS_CKS_FIRST && o <= OFS_CKS_LAST) begin
					hdr_sum = hdr_sum + SUM_W'(CKS_BLANK);
					tmp = SZ_W'(cks_acc);
					octal_feed(cks_ph, tmp, b, CKS_MASK);
					cks_acc = tmp[SUM_FIELD_W-1:0];
				end else begin
					hdr_sum = hdr_sum + SUM_W'(b);
				end
				if (b != 8'h00)
					hdr_zero = 1'b0;
				if (o >= OFS_SIZE_FIRST && o <= OFS_SIZE_LAST)
					octal_feed(size_ph, size_acc, b, SZ_MAX);
				if (o == OFS_TYPE)
					type_char = b;
				if (o == OFS_BLOCK_LAST) begin
					finish_hdr(last);
				end else begin
					blk_ofs = o + 1'b1;
					if (last)
						step_res.push_back(mk_res(EV_ERROR, ERR_SHORT, KIND_REG, '0, 8'h00, 1'b0));
				end
			end
			PH_PAYLOAD: begin
				if (last) begin
					step_res.push_back(mk_res(EV_ERROR, ERR_OVERRUN, KIND_REG, '0, 8'h00, 1'b0));
				end else begin
					blk_ofs = o + 1'b1;
					bytes_left = bytes_left - 1'b1;
					if (bytes_left == 0) begin
						step_res.push_back(mk_res(EV_PAYLOAD, ERR_NONE, KIND_REG, '0, b, 1'b1));
						blk_phase = (blk_ofs == 0) ? PH_HEADER : PH_PADDING;
					end else begin
						step_res.push_back(mk_res(EV_PAYLOAD, ERR_NONE, KIND_REG, '0, b, 1'b0));
					end
				end
			end
			PH_PADDING: begin
				blk_ofs = o + 1'b1;
				if (last)
					step_res.push_back(mk_res(EV_ERROR, ERR_NO_END, KIND_REG, '0, 8'h00, 1'b0));
				else if (blk_ofs == 0)
					blk_phase = PH_HEADER;
			end
			default: ;
		endcase
		if (step_res.size() > 0) begin
			r = step_res.pop_back();
			r.last_res = 1'b1;
			step_res.push_back(r);
		end
		if (last)
			restart_parse();
	endtask

	// octal field, right aligned, terminator in the last byte when there is room
	function automatic void put_octal(int start, int len, logic [SZ_W-1:0] v,
			logic [7:0] lead, logic [7:0] term);
		int nd;
		int pos;
		logic [SZ_W-1:0] t;
		nd = 1;
		t = v >> 3;
		while (t != 0) begin
			nd++;
			t = t >> 3;
		end
		for (int i = 0; i < len; i++)
			hdr_img[start + i] = lead;
		pos = start + len - 1;
		if (nd < len) begin
			hdr_img[pos] = term;
			pos--;
		end
		for (int i = 0; i < nd && i < len; i++)
			hdr_img[pos - i] = CH_ZERO | 8'((v >> (3 * i)) & 7);
	endfunction

	function automatic logic [7:0] pick_char(int sel);
		case (sel)
			0: return CH_SPACE;
			1: return CH_NUL;
			default: return CH_ZERO;
		endcase
	endfunction

	task automatic build_hdr(input logic [7:0] typ, input logic [SZ_W-1:0] size,
			input bit cks_bad);
		logic [SUM_W-1:0] s;
		bit noisy;
		noisy = $urandom_range(0, 1);
		for (int i = 0; i < 512; i++)
			hdr_img[i] = noisy ? 8'($urandom) : CH_NUL;
		if (!noisy)
			for (int i = 0; i < 8; i++)
				hdr_img[i] = 8'($urandom_range(8'h61, 8'h7a));
		put_octal(OFS_SIZE_FIRST, 12, size, pick_char($urandom_range(0, 2)),
			pick_char($urandom_range(0, 1)));
		hdr_img[OFS_TYPE] = typ;
		s = '0;
		for (int i = 0; i < 512; i++)
			s = s + ((i >= OFS_CKS_FIRST && i <= OFS_CKS_LAST) ?
				SUM_W'(CKS_BLANK) : SUM_W'(hdr_img[i]));
		if (cks_bad)
			s = s ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
		put_octal(OFS_CKS_FIRST, 8, SZ_W'(s), pick_char($urandom_range(0, 2)),
			pick_char($urandom_range(0, 1)));
	endtask

	task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
			input res_t t);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 60)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		stream_last <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		deframe_step(b, last);
		if (typed)
			pending_res.push_back(t);
		else
			foreach (step_res[i])
				pending_res.push_back(step_res[i]);
		if (last)
			buffers++;
		if (bytes_sent % 200 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
	endtask

	function automatic stim_row_t mk_row(row_op_t op, logic [7:0] val, logic [7:0] typ,
			logic [SZ_W-1:0] size, int cnt, bit cks_bad, bit last, bit typed,
			logic [1:0] t_ev, logic [2:0] t_err);
		stim_row_t r;
		r.op = op;
		r.val = val;
		r.typ = typ;
		r.size = size;
		r.cnt = cnt;
		r.cut = 0;
		r.cks_bad = cks_bad;
		r.last = last;
		r.typed = typed;
		r.t_ev = t_ev;
		r.t_err = t_err;
		return r;
	endfunction

	function automatic int row_len(stim_row_t r);
		case (r.op)
			OP_BYTE: return 1;
			OP_HDR, OP_ZERO: return 512;
			default: return r.cnt;
		endcase
	endfunction

	task automatic run_row(input stim_row_t r);
		int n;
		logic [7:0] b;
		res_t t;
		bit fin;
		n = row_len(r);
		if (r.cut > 0 && r.cut < n)
			n = r.cut;
		if (r.op == OP_HDR)
			build_hdr(r.typ, r.size, r.cks_bad);
		t = mk_res(r.t_ev, r.t_err, KIND_REG, '0, 8'h00, 1'b0);
		t.last_res = 1'b1;
		for (int i = 0; i < n; i++) begin
			case (r.op)
				OP_BYTE: b = r.val;
				OP_HDR: b = hdr_img[i];
				OP_ZERO: b = CH_NUL;
				default: b = 8'($urandom);
			endcase
			fin = (i == n - 1);
			send_byte(b, r.last && fin, r.typed && fin, t);
		end
	endtask

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 11))
			0, 1, 2: return CH_ZERO;
			3: return CH_NUL;
			4: return CH_DIR;
			5: return CH_HLINK;
			6: return CH_SLINK;
			7: return CH_CHR;
			8: return CH_BLK;
			9: return CH_FIFO;
			10: return CH_SEVEN;
			default: return CH_JUNK;
		endcase
	endfunction

	task automatic rand_archive();
		stim_row_t q[$];
		stim_row_t r;
		logic [7:0] typ;
		int sz;
		int data_len;
		int pad;
		int k;
		int pick;
		if ($urandom_range(0, 99) < 15) begin
			run_row(mk_row(OP_DATA, 8'h00, CH_NUL, '0, $urandom_range(1, 700), 0, 1, 0,
				EV_HEADER, ERR_NONE));
		end else begin
			repeat ($urandom_range(0, 3)) begin
				typ = pick_type();
				pick = $urandom_range(0, 99);
				if (pick < 20)
					sz = 0;
				else if (pick < 70)
					sz = $urandom_range(1, 40);
				else if (pick < 90)
					sz = $urandom_range(41, 520);
				else
					sz = $urandom_range(521, 1100);
				if (typ inside {CH_HLINK, CH_SLINK, CH_CHR, CH_BLK, CH_FIFO} &&
						$urandom_range(0, 9) != 0)
					sz = 0;
				q.push_back(mk_row(OP_HDR, 8'h00, typ, SZ_W'(sz), 0,
					$urandom_range(0, 99) < 8, 0, 0, EV_HEADER, ERR_NONE));
				data_len = (typ == CH_DIR) ? 0 : sz;
				pad = (512 - data_len % 512) % 512;
				if (data_len > 0) begin
					q.push_back(mk_row(OP_DATA, 8'h00, CH_NUL, '0, data_len, 0, 0, 0,
						EV_HEADER, ERR_NONE));
					if (pad > 0)
						q.push_back(mk_row(OP_DATA, 8'h00, CH_NUL, '0, pad, 0, 0, 0,
							EV_HEADER, ERR_NONE));
				end
			end
			q.push_back(mk_row(OP_ZERO, 8'h00, CH_NUL, '0, 0, 0, 0, 0, EV_HEADER, ERR_NONE));
			q.push_back(mk_row(OP_DATA, 8'h00, CH_NUL, '0, $urandom_range(1, 4), 0, 1, 0,
				EV_HEADER, ERR_NONE));
			// truncated buffer
			if ($urandom_range(0, 99) < 40) begin
				k = $urandom_range(0, q.size() - 1);
				r = q[k];
				r.last = 1'b1;
				r.cut = ($urandom_range(0, 2) == 0) ? row_len(r) : $urandom_range(1, row_len(r));
				q[k] = r;
				while (q.size() > k + 1)
					void'(q.pop_back());
			end
			foreach (q[i])
				run_row(q[i]);
		end
	endtask

	task automatic cmp_field(input string name, input logic [SZ_W-1:0] exp_v,
			input logic [SZ_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic check_beat();
		res_t e;
		if (pending_res.size() == 0) begin
			$display("%0t: unexpected beat, event_res %0d error_code %0d", $time,
				event_res, error_code);
			mismatches++;
		end else begin
			e = pending_res.pop_front();
			cmp_field("event_res", e.ev, event_res);
			cmp_field("error_code", e.err, error_code);
			cmp_field("entry_kind", e.kind, entry_kind);
			cmp_field("entry_size", e.size, entry_size);
			cmp_field("payload_byte", e.pbyte, payload_byte);
			cmp_field("entry_done", e.done, entry_done);
			cmp_field("step_final", e.last_res, step_final);
			res_seen++;
			ev_tally[e.ev]++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_beat();
		rx_cyc++;
		if (rx_cyc % 300 == 0)
			rx_calm = ($urandom_range(0, 3) == 0);
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else if (rx_calm) begin
			out_ready <= 1'b1;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 70) begin
				out_ready <= 1'b1;
			end else begin
				rx_stall = (rx_pick < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
				out_ready <= 1'b0;
			end
		end
	end

	initial begin
		#25_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		stim_row_t dir_rows[$];
		int dir_bytes;
		restart_parse();
		// op        val    type      size     cnt  bad last typed ev          err
		dir_rows.push_back(mk_row(OP_BYTE, 8'h00, CH_NUL,   '0,      0,   0, 1, 1, EV_ERROR,  ERR_SHORT));
		dir_rows.push_back(mk_row(OP_BYTE, 8'hff, CH_NUL,   '0,      0,   0, 1, 1, EV_ERROR,  ERR_SHORT));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_ZERO,  3,       0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      3,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      509, 0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_DIR,   7,       0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_SLINK, '0,      0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_ZERO, 8'h00, CH_NUL,   '0,      0,   0, 1, 1, EV_END,    ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_ZERO,  512,     0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      512, 0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_HLINK, SZ_MAX,  0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_BYTE, 8'h00, CH_NUL,   '0,      0,   0, 1, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_ZERO,  '0,      0,   1, 0, 1, EV_ERROR,  ERR_CHECKSUM));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      5,   0, 1, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_SEVEN, '0,      0,   0, 1, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_ZERO,  10,      0,   0, 1, 1, EV_ERROR,  ERR_OVERRUN));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_JUNK,  1000,    0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      999, 0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_BYTE, 8'h41, CH_NUL,   '0,      0,   0, 1, 1, EV_ERROR,  ERR_OVERRUN));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_ZERO,  4,       0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      3,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_BYTE, 8'h80, CH_NUL,   '0,      0,   0, 1, 1, EV_ERROR,  ERR_OVERRUN));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_CHR,   '0,      0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_BLK,   '0,      0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_FIFO,  '0,      0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_HDR,  8'h00, CH_NUL,   2,       0,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      2,   0, 0, 0, EV_HEADER, ERR_NONE));
		dir_rows.push_back(mk_row(OP_DATA, 8'h00, CH_NUL,   '0,      7,   0, 1, 1, EV_ERROR,  ERR_NO_END));
		dir_rows.push_back(mk_row(OP_ZERO, 8'h00, CH_NUL,   '0,      0,   0, 0, 1, EV_END,    ERR_NONE));
		dir_rows.push_back(mk_row(OP_BYTE, 8'h55, CH_NUL,   '0,      0,   0, 1, 0, EV_HEADER, ERR_NONE));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			run_row(dir_rows[i]);
		dir_bytes = bytes_sent;
		while (bytes_sent < dir_bytes + RANDOM_BYTES)
			rand_archive();
		in_valid <= 1'b0;

		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d buffers, checked %0d result beats",
			bytes_sent, buffers, res_seen);
		$display("headers %0d, payload bytes %0d, end blocks %0d, errors %0d",
			ev_tally[0], ev_tally[1], ev_tally[2], ev_tally[3]);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
